>>> rtl/slw_pkg.sv
// Shared types and constants for the single-level timer wheel.
package slw_pkg;

  localparam int ID_W           = 6;
  localparam int KIND_W         = 2;
  localparam int TIMEOUT_W      = 6;
  localparam int SIZE_W         = 9;
  localparam int DEF_NUM_TIMERS = 64;
  localparam int DEF_NUM_SLOTS  = 64;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 6'd16;

  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISARM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD_ADDR,
    ST_OLD_WR,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_TICK_LD,
    ST_TICK_SCAN
  } state_t;

endpackage

>>> rtl/slw_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module slw_ram import slw_pkg::*; #(
  parameter int WIDTH = DEF_NUM_TIMERS,
  parameter int DEPTH = DEF_NUM_SLOTS,
  parameter int AW    = $clog2(DEF_NUM_SLOTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/slw_ffs.sv
// Lowest-set-bit finder over one slot's membership vector.
module slw_ffs import slw_pkg::*; #(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int TW         = $clog2(DEF_NUM_TIMERS)
) (
  input  logic [NUM_TIMERS-1:0] row,
  output logic [TW-1:0]         idx,
  output logic [NUM_TIMERS-1:0] rest,
  output logic                  last
);

  logic [NUM_TIMERS-1:0] low;

  assign low  = row & (~row + {{(NUM_TIMERS-1){1'b0}}, 1'b1});
  assign rest = row & ~low;
  assign last = (rest == '0);

  always_comb begin
    idx = '0;
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if (low[j]) begin
        idx = idx | TW'(j);
      end
    end
  end

endmodule

>>> rtl/single_level_timer_wheel.sv
// Single-level timer wheel: top level with control sequencer and memories.
// Usage: each input beat carries a kind and a timer ID. Kind arm places the
// timer timeout_ticks slots ahead of the current slot, moving it if it was
// already armed; kind disarm removes an armed timer; kind tick reports
// every timer in the current slot, in ascending ID order, one output beat
// each, with last set on the final one, after emptying the slot and advancing.
// The wheel has timeout_ticks + 1 slots, at most NUM_SLOTS.
// Steps per beat: arm of an unarmed timer reads and writes its new slot;
// disarm reads the timer's slot index, then that slot, then writes it back;
// re-arm does both; a tick loads the slot, then gives one timer per output
// beat, as the slot memory has one read and one write port and both reads are registered.
// One beat is worked on at a time; in_ready is high only while idle. The
// output register lets the next input beat be taken while the last result
// still waits. If the receiver stalls, the tick scan holds until out_ready.
// Reset (synchronous, active low) and any configuration write empty the
// wheel at once through per-slot valid flags, disarm every timer and return
// the pointer to slot zero; reset also restores a timeout of 16. A
// configuration write is taken only while idle and has priority.
module single_level_timer_wheel import slw_pkg::*; #(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_W-1:0]      in_timer_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      out_expired_id,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_timeout_ticks
);

  localparam int TW = $clog2(NUM_TIMERS);
  localparam int SW = $clog2(NUM_SLOTS);

  state_t                state_r, state_nxt;
  logic [TIMEOUT_W-1:0]  timeout_r, timeout_nxt;
  logic [NUM_SLOTS-1:0]  slot_vld_r, slot_vld_nxt;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [TW-1:0]         id_r, id_nxt;
  logic                  is_arm_r, is_arm_nxt;
  logic [SW-1:0]         slot_addr_r, slot_addr_nxt;
  logic [NUM_TIMERS-1:0] row_r, row_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [SIZE_W-1:0]     size_m1;
  logic [SW-1:0]         target;
  logic [SW-1:0]         cur_inc;
  logic                  id_ok;
  logic [TW-1:0]         in_idx;
  logic [NUM_TIMERS-1:0] bit_mask;
  logic [NUM_TIMERS-1:0] tick_row;

  logic                  slot_we;
  logic [SW-1:0]         slot_waddr;
  logic [NUM_TIMERS-1:0] slot_wdata;
  logic [SW-1:0]         slot_raddr;
  logic [NUM_TIMERS-1:0] slot_rdata;
  logic                  tslot_we;
  logic [SW-1:0]         tslot_rdata;

  logic [TW-1:0]         ffs_idx;
  logic [NUM_TIMERS-1:0] ffs_rest;
  logic                  ffs_last;

  assign size_m1 = (SIZE_W'(timeout_r) >= SIZE_W'(NUM_SLOTS - 1)) ?
                   SIZE_W'(NUM_SLOTS - 1) : SIZE_W'(timeout_r);
  assign target  = (cur_r == '0) ? size_m1[SW-1:0] : cur_r - 1'b1;
  assign cur_inc = (SIZE_W'(cur_r) == size_m1) ? '0 : cur_r + 1'b1;
  assign id_ok   = ((ID_W + 1)'(in_timer_id) < (ID_W + 1)'(NUM_TIMERS));
  assign in_idx  = in_timer_id[TW-1:0];
  assign bit_mask = {{(NUM_TIMERS-1){1'b0}}, 1'b1} << id_r;
  assign tick_row = slot_vld_r[cur_r] ? slot_rdata : '0;

  slw_ram #(
    .WIDTH (NUM_TIMERS),
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  slw_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_TIMERS),
    .AW    (TW)
  ) u_tslot_ram (
    .clk   (clk),
    .we    (tslot_we),
    .waddr (id_r),
    .wdata (target),
    .raddr (in_idx),
    .rdata (tslot_rdata)
  );

  slw_ffs #(
    .NUM_TIMERS (NUM_TIMERS),
    .TW         (TW)
  ) u_ffs (
    .row  (row_r),
    .idx  (ffs_idx),
    .rest (ffs_rest),
    .last (ffs_last)
  );

  always_comb begin
    state_nxt     = state_r;
    timeout_nxt   = timeout_r;
    slot_vld_nxt  = slot_vld_r;
    armed_nxt     = armed_r;
    cur_nxt       = cur_r;
    id_nxt        = id_r;
    is_arm_nxt    = is_arm_r;
    slot_addr_nxt = slot_addr_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    slot_we       = 1'b0;
    slot_waddr    = target;
    slot_wdata    = '0;
    slot_raddr    = target;
    tslot_we      = 1'b0;
    in_ready      = 1'b0;
    cfg_ready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (in_kind == KIND_TICK) begin
          slot_raddr = cur_r;
        end
        if (cfg_valid) begin
          timeout_nxt  = cfg_timeout_ticks;
          slot_vld_nxt = '0;
          armed_nxt    = '0;
          cur_nxt      = '0;
        end else if (in_valid) begin
          id_nxt     = in_idx;
          is_arm_nxt = (in_kind == KIND_ARM);
          case (in_kind)
            KIND_ARM: begin
              if (id_ok) begin
                state_nxt = armed_r[in_idx] ? ST_OLD_ADDR : ST_NEW_WR;
              end
            end
            KIND_DISARM: begin
              if (id_ok && armed_r[in_idx]) begin
                state_nxt = ST_OLD_ADDR;
              end
            end
            KIND_TICK: begin
              state_nxt = ST_TICK_LD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_OLD_ADDR: begin
        slot_raddr    = tslot_rdata;
        slot_addr_nxt = tslot_rdata;
        state_nxt     = ST_OLD_WR;
      end
      ST_OLD_WR: begin
        slot_we       = 1'b1;
        slot_waddr    = slot_addr_r;
        slot_wdata    = (slot_vld_r[slot_addr_r] ? slot_rdata : '0) & ~bit_mask;
        slot_vld_nxt[slot_addr_r] = 1'b1;
        armed_nxt[id_r] = 1'b0;
        state_nxt     = is_arm_r ? ST_NEW_RD : ST_IDLE;
      end
      ST_NEW_RD: begin
        state_nxt = ST_NEW_WR;
      end
      ST_NEW_WR: begin
        slot_we    = 1'b1;
        slot_wdata = (slot_vld_r[target] ? slot_rdata : '0) | bit_mask;
        slot_vld_nxt[target] = 1'b1;
        tslot_we   = 1'b1;
        armed_nxt[id_r] = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_TICK_LD: begin
        row_nxt             = tick_row;
        slot_vld_nxt[cur_r] = 1'b0;
        armed_nxt           = armed_r & ~tick_row;
        cur_nxt             = cur_inc;
        state_nxt           = (tick_row == '0) ? ST_IDLE : ST_TICK_SCAN;
      end
      ST_TICK_SCAN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = ID_W'(ffs_idx);
          out_last_nxt  = ffs_last;
          row_nxt       = ffs_rest;
          if (ffs_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timeout_r   <= TIMEOUT_RST;
      slot_vld_r  <= '0;
      armed_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timeout_r   <= timeout_nxt;
      slot_vld_r  <= slot_vld_nxt;
      armed_r     <= armed_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    is_arm_r    <= is_arm_nxt;
    slot_addr_r <= slot_addr_nxt;
    row_r       <= row_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_cur_in_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(cur_r) <= size_m1)
    else $error("current slot pointer is outside the wheel");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> armed_r == '0 && slot_vld_r == '0 && cur_r == '0)
    else $error("configuration write did not empty the wheel");

  a_unlink_armed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OLD_WR |-> armed_r[id_r])
    else $error("unlinking a timer that is not armed");
`endif

endmodule
